/* rtl/ifsb_pkg.sv */
// Package for the select box mean filter: constants, codes and payload types.
package ifsb_pkg;

  localparam int unsigned IMG_SIZE  = 128;
  localparam int unsigned PAD       = 8;
  localparam int unsigned UNPAD     = IMG_SIZE - 2 * PAD;
  localparam int unsigned COORD_W   = 7;
  localparam int unsigned RING_W    = 4;
  localparam int unsigned LS_AW     = RING_W + COORD_W;
  localparam int unsigned LS_DEPTH  = 1 << LS_AW;
  localparam int unsigned CS_W      = 13;
  localparam int unsigned WS_W      = 17;
  localparam int unsigned HIST_LEN  = 32;
  localparam int unsigned HIST_AW   = 5;
  localparam int unsigned MUL_W     = 11;
  localparam int unsigned FRAC_BITS = 17;
  localparam int unsigned PROD_W    = WS_W + MUL_W;

  localparam logic [MUL_W-1:0] MUL_R4 = MUL_W'(1638);
  localparam logic [MUL_W-1:0] MUL_R8 = MUL_W'(455);

  typedef enum logic [1:0] {
    MODE_CHECKER = 2'd0,
    MODE_FRAME   = 2'd1,
    MODE_MEAN4   = 2'd2,
    MODE_MEAN8   = 2'd3
  } filter_mode_e;

  typedef struct packed {
    logic [7:0] pixel_in;
    logic       frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]         pixel_out;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               frame_last;
  } pix_out_t;

  // window radius of a mode, zero for the pixel modes
  function automatic logic [3:0] mode_radius(filter_mode_e m);
    case (m)
      MODE_MEAN4: mode_radius = 4'd4;
      MODE_MEAN8: mode_radius = 4'd8;
      default:    mode_radius = 4'd0;
    endcase
  endfunction

endpackage

/* rtl/ifsb_hist_cell.sv */
// One cell of the vertical-sum history chain: holds one entry, forwards the selected one.
module ifsb_hist_cell
  import ifsb_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            we_i,
  input  logic [CS_W-1:0] wdata_i,
  input  logic            sel_i,
  input  logic [CS_W-1:0] chain_i,
  output logic [CS_W-1:0] chain_o
);

  logic [CS_W-1:0] entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (we_i) begin
      entry_q <= wdata_i;
    end
  end

  // pass the neighbor's value on unless this cell is the one addressed
  assign chain_o = sel_i ? entry_q : chain_i;

endmodule

/* rtl/ifsb_line_store.sv */
// Ring of the last padded input rows: one write port, two registered read ports.
module ifsb_line_store
  import ifsb_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [LS_AW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [LS_AW-1:0] raddr_a_i,
  input  logic [LS_AW-1:0] raddr_b_i,
  output logic [7:0]       rdata_a_o,
  output logic [7:0]       rdata_b_o
);

  logic [7:0] mem [LS_DEPTH];
  logic [7:0] rdata_a_q;
  logic [7:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // reads return the contents from before a write at the same edge
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

/* rtl/ifsb_colsum.sv */
// Per-column vertical sums: memory with registered read and a valid bit per column.
module ifsb_colsum
  import ifsb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               we_i,
  input  logic [COORD_W-1:0] waddr_i,
  input  logic [CS_W-1:0]    wdata_i,
  input  logic               re_i,
  input  logic [COORD_W-1:0] raddr_i,
  input  logic [COORD_W-1:0] vaddr_i,
  output logic [CS_W-1:0]    rdata_o
);

  logic [CS_W-1:0] mem [IMG_SIZE];
  logic [CS_W-1:0] rdata_q;
  logic [IMG_SIZE-1:0] vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  // a column never written reads as zero
  assign rdata_o = vld_q[vaddr_i] ? rdata_q : '0;

endmodule

/* rtl/image_filter_select_box_mean.sv */
// Top level of the select box mean filter over a padded 128x128 image.
//
// Input channel: in_valid_i / in_stall_o with in_data_i (pixel and frame start),
// one padded pixel per transaction in raster order. Output channel:
// out_valid_o / out_stall_i with out_data_o (pixel, row, column, frame last).
// Configuration: cfg_valid_i / cfg_ready_o with cfg_data_i, the filter mode;
// cfg_ready_o is always high and a write takes effect at once.
// Throughput is one pixel per clock while the receiver does not stall. A result
// passes the stage registers and then the output register after the input
// transaction that causes it; in the mean modes that transaction lies the pixel
// radius rows and columns past the centre. Each input pass goes through a read of
// the line store and column-sum memories, a column and window sum update through
// the history cell chain, a multiply and saturate, and the output register.
// When the receiver stalls with a result held, the whole pipeline holds and
// in_stall_o rises in the same cycle. Reset clears the counters, the window
// sum, the history cells and the column valid bits; it empties the pipeline
// at once and needs no clearing pass. The line store is undefined until written.
module image_filter_select_box_mean
  import ifsb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  pix_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pix_out_t out_data_o,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  logic [1:0] cfg_data_i
);

  filter_mode_e mode_q;
  logic adv, accept;

  logic [COORD_W-1:0] row_q, col_q, cur_r, cur_c;
  logic [COORD_W-1:0] row_d, col_d;

  // stage 1 registers
  logic               s1_valid_q;
  logic [7:0]         s1_pix_q;
  logic [COORD_W-1:0] s1_r_q, s1_c_q;
  filter_mode_e       s1_mode_q;

  // stage 2 registers
  logic               s2_valid_q;
  logic               s2_mean_q, s2_rad8_q;
  logic [WS_W-1:0]    s2_sum_q;
  logic [7:0]         s2_val_q;
  logic [COORD_W-1:0] s2_row_q, s2_col_q;
  logic               s2_last_q;

  logic     out_valid_q;
  pix_out_t out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CHECKER;
    end else if (cfg_valid_i) begin
      mode_q <= filter_mode_e'(cfg_data_i);
    end
  end

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  // ---------------- input position and memory reads
  logic [3:0] rad_a;
  logic [4:0] two_rad_a;
  logic [LS_AW-1:0] ls_waddr, ls_old_addr, ls_ctr_addr;
  logic [RING_W-1:0] old_ring, ctr_ring;
  logic [COORD_W-1:0] ctr_col;

  always_comb begin
    cur_r = in_data_i.frame_start ? '0 : row_q;
    cur_c = in_data_i.frame_start ? '0 : col_q;
    if (cur_c == COORD_W'(IMG_SIZE - 1)) begin
      col_d = '0;
      row_d = (cur_r == COORD_W'(IMG_SIZE - 1)) ? '0 : cur_r + 1'b1;
    end else begin
      col_d = cur_c + 1'b1;
      row_d = cur_r;
    end
    rad_a       = mode_radius(mode_q);
    two_rad_a   = {rad_a, 1'b0};
    old_ring    = cur_r[RING_W-1:0] - two_rad_a[RING_W-1:0];
    ctr_ring    = cur_r[RING_W-1:0] - rad_a;
    ctr_col     = cur_c - COORD_W'(rad_a);
    ls_waddr    = {cur_r[RING_W-1:0], cur_c};
    ls_old_addr = {old_ring, cur_c};
    ls_ctr_addr = {ctr_ring, ctr_col};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  logic [7:0] ls_old, ls_ctr;

  ifsb_line_store u_line_store (
    .clk_i     (clk_i),
    .we_i      (accept),
    .waddr_i   (ls_waddr),
    .wdata_i   (in_data_i.pixel_in),
    .re_i      (accept),
    .raddr_a_i (ls_old_addr),
    .raddr_b_i (ls_ctr_addr),
    .rdata_a_o (ls_old),
    .rdata_b_o (ls_ctr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= in_data_i.pixel_in;
      s1_r_q    <= cur_r;
      s1_c_q    <= cur_c;
      s1_mode_q <= mode_q;
    end
  end

  // ---------------- stage 1: column and window sums
  logic [3:0]   rad;
  logic [4:0]   two_rad;
  logic         mean_s1, commit;
  logic [CS_W-1:0] cs_mem, cs, v, ncs;
  logic [WS_W-1:0] ws_q, ws_base, ws_n, ws_sub;
  logic [COORD_W-1:0] byp_c_q;
  logic [CS_W-1:0]    byp_v_q;
  logic               byp_vld_q;
  logic [HIST_AW-1:0] h_raddr, h_waddr;
  logic [CS_W-1:0]    h_chain [HIST_LEN+1];
  logic [CS_W-1:0]    h_rd;

  assign rad     = mode_radius(s1_mode_q);
  assign two_rad = {rad, 1'b0};
  assign mean_s1 = (rad != 4'd0);
  assign commit  = adv && s1_valid_q && mean_s1;

  ifsb_colsum u_colsum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (commit),
    .waddr_i (s1_c_q),
    .wdata_i (ncs),
    .re_i    (accept),
    .raddr_i (cur_c),
    .vaddr_i (s1_c_q),
    .rdata_o (cs_mem)
  );

  assign h_raddr = HIST_AW'(s1_c_q - COORD_W'(two_rad) - 1'b1);
  assign h_waddr = s1_c_q[HIST_AW-1:0];
  assign h_chain[0] = '0;
  assign h_rd = h_chain[HIST_LEN];

  for (genvar i = 0; i < HIST_LEN; i++) begin : g_hist
    ifsb_hist_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .we_i    (commit && (h_waddr == HIST_AW'(i))),
      .wdata_i (v),
      .sel_i   (h_raddr == HIST_AW'(i)),
      .chain_i (h_chain[i]),
      .chain_o (h_chain[i+1])
    );
  end

  always_comb begin
    // start from zero on row 0, and take the last written column sum when the memory read missed it
    if (s1_r_q == '0) begin
      cs = '0;
    end else if (byp_vld_q && (byp_c_q == s1_c_q)) begin
      cs = byp_v_q;
    end else begin
      cs = cs_mem;
    end
    v = cs + CS_W'(s1_pix_q);
    if (s1_r_q >= COORD_W'(two_rad)) begin
      ncs = v - CS_W'(ls_old);
    end else begin
      ncs = v;
    end
    ws_base = (s1_c_q == '0) ? '0 : ws_q;
    ws_sub  = (s1_c_q >= COORD_W'(two_rad) + 1'b1) ? WS_W'(h_rd) : '0;
    ws_n    = ws_base + WS_W'(v) - ws_sub;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q      <= '0;
      byp_vld_q <= 1'b0;
      byp_c_q   <= '0;
      byp_v_q   <= '0;
    end else if (commit) begin
      ws_q      <= ws_n;
      byp_vld_q <= 1'b1;
      byp_c_q   <= s1_c_q;
      byp_v_q   <= ncs;
    end
  end

  // ---------------- stage 1: output selection
  logic [COORD_W-1:0] off, orow, ocol;
  logic produce, edge_px;
  logic [7:0] val01;

  always_comb begin
    off     = COORD_W'(PAD) + COORD_W'(rad);
    orow    = s1_r_q - off;
    ocol    = s1_c_q - off;
    produce = s1_valid_q && (s1_r_q >= off) && (s1_c_q >= off) &&
              (orow < COORD_W'(UNPAD)) && (ocol < COORD_W'(UNPAD));
    edge_px = (orow == '0) || (orow == COORD_W'(UNPAD - 1)) ||
              (ocol == '0) || (ocol == COORD_W'(UNPAD - 1));
    if (s1_mode_q == MODE_CHECKER) begin
      val01 = (s1_r_q[0] ^ s1_c_q[0]) ? s1_pix_q : 8'd0;
    end else begin
      val01 = edge_px ? 8'd0 : s1_pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= produce;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_mean_q <= mean_s1;
      s2_rad8_q <= (s1_mode_q == MODE_MEAN8);
      s2_sum_q  <= ws_n - WS_W'(ls_ctr);
      s2_val_q  <= val01;
      s2_row_q  <= orow;
      s2_col_q  <= ocol;
      s2_last_q <= (orow == COORD_W'(UNPAD - 1)) && (ocol == COORD_W'(UNPAD - 1));
    end
  end

  // ---------------- stage 2: scale the window sum
  logic [PROD_W-1:0] prod;
  logic [PROD_W-FRAC_BITS-1:0] mean_full;
  logic [7:0] mean_val;

  always_comb begin
    prod      = PROD_W'(s2_sum_q) * PROD_W'(s2_rad8_q ? MUL_R8 : MUL_R4);
    mean_full = prod[PROD_W-1:FRAC_BITS];
    mean_val  = (mean_full > 11'd255) ? 8'd255 : mean_full[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.pixel_out  <= s2_mean_q ? mean_val : s2_val_q;
      out_q.out_row    <= s2_row_q;
      out_q.out_col    <= s2_col_q;
      out_q.frame_last <= s2_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------- assertions
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.frame_last) |->
      (out_q.out_row == COORD_W'(UNPAD - 1)) && (out_q.out_col == COORD_W'(UNPAD - 1)))
    else $error("frame_last away from the last interior pixel");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.out_row < COORD_W'(UNPAD)) && (out_q.out_col < COORD_W'(UNPAD)))
    else $error("output coordinate outside the interior");

  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !adv) |=> s2_valid_q)
    else $error("stage 2 result dropped while stalled");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv) |=> (s1_valid_q && $stable(s1_c_q) && $stable(s1_r_q)))
    else $error("stage 1 item changed while stalled");

endmodule
